// File: rtl/core/psm_pkg.sv
// Shared types, constants and signature table for the packet URI signature matcher.
`timescale 1ns / 1ps

package psm_pkg;

  // Bytes held behind the current one, and the compare span including it.
  localparam int WINDOW_DEPTH = 36;
  localparam int TAIL_LEN     = WINDOW_DEPTH + 1;
  localparam int TAIL_W       = TAIL_LEN * 8;

  // Byte counter width; it saturates at its all-ones value.
  localparam int POS_W = 16;

  localparam int SIG_COUNT = 4;

  // Flag order: server-info, setupComplete, setup admin, oauth icon.
  localparam int SIG_SERVER_INFO = 0;
  localparam int SIG_SETUP_DONE  = 1;
  localparam int SIG_SETUP_ADMIN = 2;
  localparam int SIG_OAUTH_ICON  = 3;

  localparam int SIG_LEN [SIG_COUNT] = '{19, 19, 32, 37};

  // Each string sits right-justified, so byte j from the bottom is the
  // character j places before the end of the signature.
  localparam logic [TAIL_W-1:0] SIG_TEXT [SIG_COUNT] = '{
    "/server-info.action",
    "setupComplete=false",
    "/setup/setupadministrator.action",
    "/plugins/servlet/oauth/users/icon-uri"
  };

  localparam int DEFAULT_SCAN_BYTES      = 512;
  localparam int DEFAULT_MAX_PATTERN_LEN = 48;

  localparam logic [1:0] VERDICT_NONE        = 2'd0;
  localparam logic [1:0] VERDICT_SERVER_INFO = 2'd1;
  localparam logic [1:0] VERDICT_SETUP_ADMIN = 2'd2;
  localparam logic [1:0] VERDICT_OAUTH_ICON  = 2'd3;

  // Current byte in the lowest byte, older bytes above it.
  typedef logic [TAIL_W-1:0] tail_t;
  typedef logic [SIG_COUNT-1:0] sig_flags_t;

endpackage

// File: rtl/core/psm_window.sv
// Shift register of the most recent packet bytes, presented with the current byte.
`timescale 1ns / 1ps

module psm_window (
  input  logic           clk,
  input  logic           shift_en,
  input  logic [7:0]     data_byte,
  output psm_pkg::tail_t tail
);
  import psm_pkg::*;

  logic [7:0] window [WINDOW_DEPTH];

  // Stale bytes from an earlier packet are never compared: the matcher
  // requires enough bytes of the current packet first.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      window[0] <= data_byte;
      for (int k = 1; k < WINDOW_DEPTH; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  always_comb begin
    tail[7:0] = data_byte;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      tail[8*(k+1) +: 8] = window[k];
    end
  end

endmodule

// File: rtl/core/psm_sig_match.sv
// Parallel compare of the four signatures against the bytes ending at the current one.
`timescale 1ns / 1ps

module psm_sig_match #(
  parameter int SCAN_BYTES      = psm_pkg::DEFAULT_SCAN_BYTES,
  parameter int MAX_PATTERN_LEN = psm_pkg::DEFAULT_MAX_PATTERN_LEN
) (
  input  psm_pkg::tail_t               tail,
  input  logic [psm_pkg::POS_W-1:0]    position,
  output psm_pkg::sig_flags_t          hit
);
  import psm_pkg::*;

  localparam int CMP_W = POS_W + 1;

  logic [CMP_W-1:0] pos_ext;
  logic             in_scan;
  sig_flags_t       text_eq;

  assign pos_ext = {1'b0, position};
  assign in_scan = pos_ext < CMP_W'(SCAN_BYTES);

  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      text_eq[s] = 1'b1;
      for (int j = 0; j < TAIL_LEN; j++) begin
        if (j < SIG_LEN[s] && tail[8*j +: 8] != SIG_TEXT[s][8*j +: 8]) begin
          text_eq[s] = 1'b0;
        end
      end
    end
  end

  // A match needs the whole signature inside this packet and must start
  // below the end of the scan region less the longest pattern.
  for (genvar g = 0; g < SIG_COUNT; g++) begin : g_sig
    localparam int FIRST_POS = SIG_LEN[g] - 1;
    localparam int END_POS   = SCAN_BYTES - MAX_PATTERN_LEN + SIG_LEN[g] - 1;
    assign hit[g] = text_eq[g] && in_scan
                    && (pos_ext >= CMP_W'(FIRST_POS))
                    && (pos_ext < CMP_W'(END_POS));
  end

endmodule

// File: rtl/core/packet_uri_signature_matcher.sv
// Top level of the packet URI signature matcher: input stage, packet state and verdict output.
`timescale 1ns / 1ps

// Packet bytes enter one item per cycle on the slave stream, with tlast on
// the final byte and tuser set for inbound HTTP packets. Each item is held in
// an input register, compared combinationally against four fixed signatures
// by parallel byte comparators over a 37-byte window, and on the last byte of an
// HTTP packet one verdict item is loaded into the output register. A byte is accepted
// every cycle while the output side takes results; a verdict is offered from the
// output register after its last byte leaves the input register. Only the first
// SCAN_BYTES bytes are scanned, and a match must start before SCAN_BYTES - MAX_PATTERN_LEN.
// Verdicts: 1 server-info with setupComplete=false, 2 setup admin URI,
// 3 oauth icon URI, 0 none, in that priority. Non-HTTP packets give no item.
module packet_uri_signature_matcher #(
  parameter int SCAN_BYTES      = psm_pkg::DEFAULT_SCAN_BYTES,
  parameter int MAX_PATTERN_LEN = psm_pkg::DEFAULT_MAX_PATTERN_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  input  logic       s_tuser,   // [0] http_inbound
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);
  import psm_pkg::*;

  logic             in_vld;
  logic [7:0]       in_byte;
  logic             in_last;
  logic             in_http;
  logic             advance;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  sig_flags_t       found_flags;
  sig_flags_t       found_flags_next;
  sig_flags_t       hit;
  sig_flags_t       seen;
  tail_t            tail;

  logic             out_vld;
  logic [1:0]       out_verdict;
  logic [1:0]       verdict_next;

  // The held item moves on when the output register is free or emptying.
  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
      in_http <= s_tuser;
    end
  end

  psm_window u_window (
    .clk       (clk),
    .shift_en  (advance),
    .data_byte (in_byte),
    .tail      (tail)
  );

  psm_sig_match #(
    .SCAN_BYTES      (SCAN_BYTES),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_sig_match (
    .tail     (tail),
    .position (byte_position),
    .hit      (hit)
  );

  assign seen = found_flags | hit;

  always_comb begin
    if (seen[SIG_SERVER_INFO] && seen[SIG_SETUP_DONE]) begin
      verdict_next = VERDICT_SERVER_INFO;
    end else if (seen[SIG_SETUP_ADMIN]) begin
      verdict_next = VERDICT_SETUP_ADMIN;
    end else if (seen[SIG_OAUTH_ICON]) begin
      verdict_next = VERDICT_OAUTH_ICON;
    end else begin
      verdict_next = VERDICT_NONE;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    found_flags_next   = found_flags;
    if (advance) begin
      if (in_last) begin
        byte_position_next = '0;
        found_flags_next   = '0;
      end else begin
        found_flags_next = seen;
        if (byte_position != {POS_W{1'b1}}) begin
          byte_position_next = byte_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      found_flags   <= '0;
    end else begin
      byte_position <= byte_position_next;
      found_flags   <= found_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && in_last && in_http) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last && in_http) begin
      out_verdict <= verdict_next;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {6'b0, out_verdict};

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> byte_position == '0 && found_flags == '0)
    else $error("packet state not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && !in_last && byte_position != {POS_W{1'b1}}
    |=> byte_position == $past(byte_position) + POS_W'(1))
    else $error("byte count did not advance");

  a_no_result_non_http: assert property (@(posedge clk) disable iff (rst)
    advance && in_last && !in_http |=> !m_tvalid)
    else $error("result produced for a non-HTTP packet");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_vld && out_vld && !m_tready |-> !s_tready)
    else $error("input accepted while held item is blocked");
`endif

endmodule

// File: test/packet_uri_signature_matcher_tb.sv
// Self-checking testbench for the packet URI signature matcher: directed and random packets.
`timescale 1ns / 1ps

module packet_uri_signature_matcher_tb;
  import psm_pkg::*;

  localparam int SCAN_LIMIT     = 512;
  localparam int PATTERN_MARGIN = 48;
  localparam int STALL_CYCLES   = 400;
  localparam int CYCLE_LIMIT    = 1000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  packet_uri_signature_matcher #(
    .SCAN_BYTES     (SCAN_LIMIT),
    .MAX_PATTERN_LEN(PATTERN_MARGIN)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int stalls_requested = 0;
  int stalls_served = 0;
  int stall_left = 0;

  logic [1:0] verdict_q [$];
  logic [7:0] pkt_q [$];

  // Shadow of the matcher's packet state.
  logic [7:0]  recent_bytes [WINDOW_DEPTH];
  int unsigned byte_count;
  logic [3:0]  sig_seen;

  function automatic string sig_text(input int s);
    case (s)
      SIG_SERVER_INFO: return "/server-info.action";
      SIG_SETUP_DONE:  return "setupComplete=false";
      SIG_SETUP_ADMIN: return "/setup/setupadministrator.action";
      default:         return "/plugins/servlet/oauth/users/icon-uri";
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic clear_packet_state();
    foreach (recent_bytes[k]) recent_bytes[k] = 8'd0;
    byte_count = 0;
    sig_seen = '0;
  endtask

  // Applies one accepted byte to the shadow state and queues a verdict when due.
  task automatic track_byte(input logic [7:0] b, input logic last, input logic http);
    logic [7:0] tail [WINDOW_DEPTH+1];
    string txt;
    int n;
    bit hit;
    logic [1:0] v;
    tail[0] = b;
    for (int k = 0; k < WINDOW_DEPTH; k++) tail[k+1] = recent_bytes[k];
    if (byte_count < SCAN_LIMIT) begin
      for (int s = 0; s < SIG_COUNT; s++) begin
        txt = sig_text(s);
        n = txt.len();
        if (byte_count + 1 >= n && byte_count + 1 - n < SCAN_LIMIT - PATTERN_MARGIN) begin
          hit = 1'b1;
          for (int j = 0; j < n; j++) begin
            if (tail[j] != 8'(txt[n-1-j])) hit = 1'b0;
          end
          if (hit) sig_seen[s] = 1'b1;
        end
      end
    end
    for (int k = 0; k < WINDOW_DEPTH; k++) recent_bytes[k] = tail[k];
    if (byte_count < 16'hFFFF) byte_count++;
    if (last) begin
      if (sig_seen[SIG_SERVER_INFO] && sig_seen[SIG_SETUP_DONE]) v = VERDICT_SERVER_INFO;
      else if (sig_seen[SIG_SETUP_ADMIN]) v = VERDICT_SETUP_ADMIN;
      else if (sig_seen[SIG_OAUTH_ICON]) v = VERDICT_OAUTH_ICON;
      else v = VERDICT_NONE;
      clear_packet_state();
      if (http) verdict_q.push_back(v);
    end
  endtask

  // Both handshakes are sampled at the same edge, inputs first.
  always @(posedge clk) begin : scoreboard
    logic [1:0] want;
    if (rst) begin
      clear_packet_state();
    end else begin
      if (s_tvalid && s_tready) track_byte(s_tdata, s_tlast, s_tuser);
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with no packet pending", int'(m_tdata), 0);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[1:0] != want) begin
            report_mismatch("verdict", int'(m_tdata[1:0]), int'(want));
          end
          if (m_tdata[7:2] != 6'd0) report_mismatch("tdata padding", int'(m_tdata[7:2]), 0);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_served != stalls_requested) begin
      m_tready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stalls_served <= stalls_served + 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last, input logic http);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= http;
    do @(posedge clk); while (!s_tready);
  endtask

  // Sends the bytes in pkt_q as one packet. With wobble set, the HTTP flag is
  // random on all but the final byte, where the block samples it.
  task automatic send_packet(input logic http, input bit wobble = 1'b0);
    int n;
    logic last;
    n = pkt_q.size();
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1);
      send_item(pkt_q[i], last, (last || !wobble) ? http : 1'($urandom_range(0, 1)));
    end
    pkt_q.delete();
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) pkt_q.push_back(8'(t[i]));
  endtask

  // Filler mixes arbitrary bytes with signature characters to provoke near misses.
  task automatic add_noise(input int n);
    string t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) begin
        pkt_q.push_back(8'($urandom));
      end else begin
        t = sig_text($urandom_range(0, SIG_COUNT - 1));
        pkt_q.push_back(8'(t[$urandom_range(0, t.len() - 1)]));
      end
    end
  endtask

  task automatic add_broken(input int s);
    string t;
    int pos;
    t = sig_text(s);
    pos = $urandom_range(0, t.len() - 1);
    case ($urandom_range(0, 2))
      0: t[pos] = t[pos] ^ 8'(1 << $urandom_range(0, 7));
      1: t = t.substr(1, t.len() - 1);
      default: t = t.substr(0, t.len() - 2);
    endcase
    add_text(t);
  endtask

  task automatic build_random_packet();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 75) begin
      add_noise(($urandom_range(0, 19) == 0) ? $urandom_range(420, 470) : $urandom_range(0, 40));
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 1)) begin
          add_text(sig_text($urandom_range(0, SIG_COUNT - 1)));
          add_noise($urandom_range(0, 6));
        end
      end
      add_noise($urandom_range(0, 12));
    end else if (mode < 90) begin
      add_noise($urandom_range(0, 20));
      add_broken($urandom_range(0, SIG_COUNT - 1));
      add_noise($urandom_range(0, 5));
    end else begin
      add_noise($urandom_range(1, 40));
    end
    if (pkt_q.size() == 0) add_noise(1);
  endtask

  task automatic test_directed_cases();
    string t;
    // Single-byte packets at both ends of the byte range.
    pkt_q.push_back(8'h00);
    send_packet(1'b1);
    pkt_q.push_back(8'hFF);
    send_packet(1'b0);
    // Three signatures alone, the pair, and the priority combinations.
    add_text(sig_text(SIG_SETUP_ADMIN));
    send_packet(1'b1);
    add_noise(5); add_text(sig_text(SIG_SERVER_INFO)); add_noise(3);
    send_packet(1'b1);
    add_text(sig_text(SIG_SETUP_DONE)); add_text(sig_text(SIG_SERVER_INFO));
    send_packet(1'b1);
    add_noise(2); add_text(sig_text(SIG_OAUTH_ICON));
    send_packet(1'b1);
    add_text(sig_text(SIG_OAUTH_ICON)); add_text(sig_text(SIG_SETUP_ADMIN));
    add_text(sig_text(SIG_SERVER_INFO)); add_text(sig_text(SIG_SETUP_DONE));
    send_packet(1'b1);
    add_text(sig_text(SIG_OAUTH_ICON)); add_noise(4); add_text(sig_text(SIG_SETUP_ADMIN));
    send_packet(1'b1);
    add_text(sig_text(SIG_SETUP_DONE)); add_text(sig_text(SIG_OAUTH_ICON));
    send_packet(1'b1);
    // A match in a non-HTTP packet gives no verdict.
    add_text(sig_text(SIG_SETUP_ADMIN));
    send_packet(1'b0);
    // A signature split across two packets must not match.
    t = sig_text(SIG_OAUTH_ICON);
    add_text(t.substr(0, 19));
    send_packet(1'b1);
    add_text(t.substr(20, t.len() - 1));
    send_packet(1'b1);
    // A signature with one character missing.
    t = sig_text(SIG_SETUP_ADMIN);
    add_text(t.substr(0, t.len() - 2));
    send_packet(1'b1);
    // Start offset right at the scan boundary: the last allowed start, then one past it.
    add_text(sig_text(SIG_SETUP_DONE));
    add_noise(SCAN_LIMIT - PATTERN_MARGIN - 1 - pkt_q.size());
    add_text(sig_text(SIG_SERVER_INFO));
    send_packet(1'b1);
    add_text(sig_text(SIG_SETUP_DONE));
    add_noise(SCAN_LIMIT - PATTERN_MARGIN - pkt_q.size());
    add_text(sig_text(SIG_SERVER_INFO));
    add_noise(8);
    send_packet(1'b1);
    wait_results_done();
  endtask

  task automatic test_random_packets(input int byte_budget);
    int sent;
    sent = 0;
    while (sent < byte_budget) begin
      build_random_packet();
      sent += pkt_q.size();
      send_packet(($urandom_range(0, 99) < 85), ($urandom_range(0, 9) == 0));
    end
    wait_results_done();
  endtask

  // Single-byte HTTP packets against a long output stall fill the block.
  task automatic test_output_stall();
    stalls_requested++;
    for (int i = 0; i < 40; i++) begin
      pkt_q.push_back(8'($urandom));
      send_packet(1'b1);
    end
    wait_results_done();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 64;
    test_directed_cases();
    test_random_packets(100);
    test_output_stall();
    send_idle_pct = 64;
    recv_idle_pct = 36;
    test_random_packets(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_packets(100);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
